/* hw/rtl/blc_pkg.sv */
// ----------------------------------------------------------------------------
// blc_pkg
// Shared types, codes and the level code function of the bisection level
// calibrator.
// ----------------------------------------------------------------------------
package blc_pkg;

  localparam int LEVEL_W   = 18;
  localparam int SETTING_W = 9;
  localparam int CODE_W    = 13;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TARGET_LEVEL = 2'd0;
  localparam logic [1:0] REG_SETTING_MIN  = 2'd1;
  localparam logic [1:0] REG_SETTING_MAX  = 2'd2;

  localparam logic [LEVEL_W-1:0]   TARGET_LEVEL_RST = 18'd4800;
  localparam logic [SETTING_W-1:0] SETTING_MIN_RST  = 9'd80;
  localparam logic [SETTING_W-1:0] SETTING_MAX_RST  = 9'd400;

  // Input actions
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PROBE   = 2'd0;
  localparam logic [1:0] KIND_FINAL   = 2'd1;
  localparam logic [1:0] KIND_ABORT   = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // Outcomes
  localparam logic [1:0] OC_SEARCHING     = 2'd0;
  localparam logic [1:0] OC_MATCHED       = 2'd1;
  localparam logic [1:0] OC_LOW_AT_TARGET = 2'd2;
  localparam logic [1:0] OC_CEILING       = 2'd3;

  typedef struct packed {
    logic                 action;
    logic [LEVEL_W-1:0]   measured_level;
  } blc_in_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [SETTING_W-1:0] setting_nits;
    logic [CODE_W-1:0]    level_code;
    logic [1:0]           outcome;
  } blc_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   target_level;
    logic [SETTING_W-1:0] setting_min;
    logic [SETTING_W-1:0] setting_max;
  } blc_cfg_t;

  // (nits*1000+40)/80 reduces to (25*nits+1)/2
  function automatic logic [CODE_W-1:0] level_code_of(input logic [SETTING_W-1:0] nits);
    logic [CODE_W:0] prod;
    prod = {5'd0, nits} * 14'd25 + 14'd1;
    return prod[CODE_W:1];
  endfunction

endpackage

/* hw/rtl/bisection_level_calibrator.sv */
// ----------------------------------------------------------------------------
// bisection_level_calibrator
// Bisection search for the slider setting whose measured level best matches
// a programmed target, with a one-word-per-cycle stream interface while unstalled.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the input is not stalled and
// gives one result word per input word: the word is latched in the input
// register, then decided against the search state and loaded into the
// result register. A start word (action 0) requests a probe at setting_min;
// the next measurement requests a probe at setting_max; later measurements
// either close the search or request the midpoint of the remaining range.
// Each request carries level_code = (setting_nits*1000+40)/80. A measurement
// that arrives while no search is running is answered with an "ignored"
// word. The input side stalls only while the result register is full and
// stalled downstream, so a stream with no output backpressure runs at a
// sustained rate of one word per cycle. Registers target_level, setting_min
// and setting_max sit at byte addresses 0, 4 and 8; write them only while
// the block holds no unfinished word.
// ----------------------------------------------------------------------------
module bisection_level_calibrator
  import blc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  blc_in_t             in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output blc_out_t            out_data
);

  blc_cfg_t cfg;
  blc_in_t  in_q;
  logic     in_full;
  logic     accept;
  logic     advance;
  blc_out_t res;

  blc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blc_search u_search (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (in_q),
    .res  (res)
  );

  // Move the held word into the result register when that register is free
  // or is being drained this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register: hold the word until the decision stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  // Result register: load on advance, drop once taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  // Every decision lands in the result register
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("decided word lost");

  // Input stalls only while a word is held and the result side is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // A held word with a free result register always moves on
  assert property (@(posedge clk) disable iff (rst)
    (in_full && !out_valid) |=> (out_valid && $past(advance)))
    else $error("held word did not advance");

endmodule

/* hw/rtl/blc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// blc_cfg_regs
// APB-style register file: target level and the searched setting range.
// ----------------------------------------------------------------------------
module blc_cfg_regs
  import blc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output blc_cfg_t            cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level <= TARGET_LEVEL_RST;
      cfg.setting_min  <= SETTING_MIN_RST;
      cfg.setting_max  <= SETTING_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_LEVEL: cfg.target_level <= pwdata[LEVEL_W-1:0];
        REG_SETTING_MIN:  cfg.setting_min  <= pwdata[SETTING_W-1:0];
        REG_SETTING_MAX:  cfg.setting_max  <= pwdata[SETTING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TARGET_LEVEL: prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg.target_level};
      REG_SETTING_MIN:  prdata = {{(DATA_W-SETTING_W){1'b0}}, cfg.setting_min};
      REG_SETTING_MAX:  prdata = {{(DATA_W-SETTING_W){1'b0}}, cfg.setting_max};
      default:          prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/blc_search.sv */
// ----------------------------------------------------------------------------
// blc_search
// Search state and the per-word decision: endpoint checks, bisection step,
// closest-end pick and the result word.
// ----------------------------------------------------------------------------
module blc_search
  import blc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  blc_cfg_t  cfg,
  input  logic      fire,
  input  blc_in_t   item,
  output blc_out_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_BISECT
  } phase_t;

  phase_t               phase, phase_next;
  logic [SETTING_W-1:0] low_setting, low_setting_next;
  logic [SETTING_W-1:0] high_setting, high_setting_next;
  logic [SETTING_W-1:0] probe_setting, probe_setting_next;
  logic [LEVEL_W-1:0]   low_reading, low_reading_next;
  logic [LEVEL_W-1:0]   high_reading, high_reading_next;

  // Candidate ends after this measurement
  logic [SETTING_W-1:0] e_ls, e_hs;
  logic [LEVEL_W-1:0]   e_lr, e_hr;
  logic                 bisect_go;
  logic [SETTING_W:0]   mid_sum;
  logic                 closer_low;
  logic [SETTING_W-1:0] pick;
  logic [LEVEL_W-1:0]   m, t;
  logic                 m_zero, m_below;
  logic [1:0]           kind;
  logic [SETTING_W-1:0] nits;
  logic [1:0]           outcome;

  function automatic logic [LEVEL_W-1:0] level_gap(input logic [LEVEL_W-1:0] a,
                                                    input logic [LEVEL_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign m       = item.measured_level;
  assign t       = cfg.target_level;
  assign m_zero  = (m == '0);
  assign m_below = (m < t);

  always_comb begin
    e_ls = low_setting;
    e_hs = high_setting;
    e_lr = low_reading;
    e_hr = high_reading;
    if (phase == PH_WAIT_HIGH) begin
      e_hr = m;
    end else if (phase == PH_BISECT && !m_zero) begin
      if (m_below) begin
        e_ls = probe_setting;
        e_lr = m;
      end else begin
        e_hs = probe_setting;
        e_hr = m;
      end
    end
  end

  assign bisect_go  = {1'b0, e_hs} > ({1'b0, e_ls} + 10'd1);
  assign mid_sum    = {1'b0, e_ls} + {1'b0, e_hs};
  assign closer_low = level_gap(e_lr, t) <= level_gap(e_hr, t);
  assign pick       = closer_low ? e_ls : e_hs;

  always_comb begin
    phase_next         = phase;
    low_setting_next   = low_setting;
    high_setting_next  = high_setting;
    probe_setting_next = probe_setting;
    low_reading_next   = low_reading;
    high_reading_next  = high_reading;
    kind    = KIND_IGNORED;
    nits    = '0;
    outcome = OC_SEARCHING;

    if (item.action == ACT_START) begin
      low_setting_next   = cfg.setting_min;
      high_setting_next  = cfg.setting_max;
      probe_setting_next = cfg.setting_min;
      low_reading_next   = '0;
      high_reading_next  = '0;
      phase_next         = PH_WAIT_LOW;
      kind               = KIND_PROBE;
      nits               = cfg.setting_min;
    end else begin
      case (phase)
        PH_WAIT_LOW: begin
          low_reading_next   = m;
          probe_setting_next = high_setting;
          phase_next         = PH_WAIT_HIGH;
          kind               = KIND_PROBE;
          nits               = high_setting;
        end
        PH_WAIT_HIGH: begin
          high_reading_next = m;
          if (low_reading == '0 || m_zero) begin
            phase_next = PH_IDLE;
            kind       = KIND_ABORT;
          end else if (low_reading >= t) begin
            phase_next = PH_IDLE;
            kind       = KIND_FINAL;
            nits       = low_setting;
            outcome    = OC_LOW_AT_TARGET;
          end else if (m_below) begin
            phase_next = PH_IDLE;
            kind       = KIND_FINAL;
            nits       = high_setting;
            outcome    = OC_CEILING;
          end else if (bisect_go) begin
            probe_setting_next = mid_sum[SETTING_W:1];
            phase_next         = PH_BISECT;
            kind               = KIND_PROBE;
            nits               = mid_sum[SETTING_W:1];
          end else begin
            phase_next = PH_IDLE;
            kind       = KIND_FINAL;
            nits       = pick;
            outcome    = OC_MATCHED;
          end
        end
        PH_BISECT: begin
          low_setting_next  = e_ls;
          high_setting_next = e_hs;
          low_reading_next  = e_lr;
          high_reading_next = e_hr;
          if (!m_zero && bisect_go) begin
            probe_setting_next = mid_sum[SETTING_W:1];
            kind               = KIND_PROBE;
            nits               = mid_sum[SETTING_W:1];
          end else begin
            phase_next = PH_IDLE;
            kind       = KIND_FINAL;
            nits       = pick;
            outcome    = OC_MATCHED;
          end
        end
        default: begin
          kind = KIND_IGNORED;
        end
      endcase
    end

    res.kind         = kind;
    res.setting_nits = nits;
    res.level_code   = level_code_of(nits);
    res.outcome      = outcome;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      low_setting   <= '0;
      high_setting  <= '0;
      probe_setting <= '0;
      low_reading   <= '0;
      high_reading  <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      low_setting   <= low_setting_next;
      high_setting  <= high_setting_next;
      probe_setting <= probe_setting_next;
      low_reading   <= low_reading_next;
      high_reading  <= high_reading_next;
    end
  end

  // Final, abort and ignored words all leave the search idle
  assert property (@(posedge clk) disable iff (rst)
    (fire && (res.kind == KIND_FINAL || res.kind == KIND_ABORT)) |=> phase == PH_IDLE)
    else $error("search not idle after a closing word");

  // A probe always lies inside the current ends during bisection
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BISECT) |-> (probe_setting > low_setting && probe_setting < high_setting))
    else $error("bisection probe outside the ends");

  // Measurements in idle change nothing
  assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_IDLE && item.action == ACT_MEASURE) |=> phase == PH_IDLE)
    else $error("idle measurement moved the search");

endmodule
